@@ hw/rtl/coverage_novelty_check_macros.svh @@
// Assertion macros shared by the coverage novelty check RTL.
`ifndef COVERAGE_NOVELTY_CHECK_MACROS_SVH
`define COVERAGE_NOVELTY_CHECK_MACROS_SVH

// Same-cycle implication, off while reset is high
`define CNC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("coverage novelty check: same-cycle rule broken");

// Next-cycle implication, off while reset is high
`define CNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("coverage novelty check: next-cycle rule broken");

`endif

@@ hw/rtl/cnc_pkg.sv @@
// Shared types, codes and classification functions of the coverage novelty check.
`default_nettype none
package cnc_pkg;

  localparam int MapEntriesDefault = 65536;
  localparam int CfgW              = 17;
  localparam int ByteW             = 8;
  localparam int MapBytesReset     = 65536;

  // Trace selector codes; the spare code selects the crash map
  localparam logic [1:0] FuncMain    = 2'd0;
  localparam logic [1:0] FuncTimeout = 2'd1;
  localparam logic [1:0] FuncCrash   = 2'd2;
  localparam logic [1:0] FuncSpare   = 2'd3;

  // Byte lanes of one virgin word
  localparam logic [1:0] LaneMain    = 2'd0;
  localparam logic [1:0] LaneTimeout = 2'd1;
  localparam logic [1:0] LaneCrash   = 2'd2;

  // Novelty codes
  localparam logic [1:0] NovNone   = 2'd0;
  localparam logic [1:0] NovCounts = 2'd1;
  localparam logic [1:0] NovTuples = 2'd2;

  // One virgin word: the three maps' bytes at one map position
  typedef logic [2:0][ByteW-1:0] vword_t;

  // Item handed from the accept stage to the update stage
  typedef struct packed {
    logic [1:0]       lane;
    logic [ByteW-1:0] cls;
    logic             last;
  } s1_item_t;

  // Bucket a raw hit count into its count class
  function automatic logic [ByteW-1:0] bucket(input logic [ByteW-1:0] raw);
    logic [ByteW-1:0] b;
    if (raw <= 8'd2)        b = raw;
    else if (raw == 8'd3)   b = 8'd4;
    else if (raw <= 8'd7)   b = 8'd8;
    else if (raw <= 8'd15)  b = 8'd16;
    else if (raw <= 8'd31)  b = 8'd32;
    else if (raw <= 8'd127) b = 8'd64;
    else                    b = 8'd128;
    return b;
  endfunction

  // Bucket, then simplify for hang and crash traces
  function automatic logic [ByteW-1:0] classify(input logic [ByteW-1:0] raw,
                                                input logic [1:0] func);
    logic [ByteW-1:0] b;
    b = bucket(raw);
    if (func != FuncMain) begin
      b = (b == '0) ? 8'd1 : 8'd128;
    end
    return b;
  endfunction

  // Virgin map lane that a selector code names
  function automatic logic [1:0] lane_of(input logic [1:0] func);
    logic [1:0] l;
    if (func == FuncMain)         l = LaneMain;
    else if (func == FuncTimeout) l = LaneTimeout;
    else                          l = LaneCrash;
    return l;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cnc_vmem.sv @@
// Virgin map memory: one three-byte word per map position, registered read.
`default_nettype none
module cnc_vmem #(
  parameter int MAP_ENTRIES = cnc_pkg::MapEntriesDefault,
  parameter int AW          = $clog2(MAP_ENTRIES)
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output cnc_pkg::vword_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  cnc_pkg::vword_t wr_data
);

  cnc_pkg::vword_t mem [MAP_ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cnc_seq.sv @@
// Map position counter, length register and post-reset clearing pass.
`default_nettype none
`include "coverage_novelty_check_macros.svh"
module cnc_seq #(
  parameter int MAP_ENTRIES = cnc_pkg::MapEntriesDefault,
  parameter int AW          = $clog2(MAP_ENTRIES)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr,
  input  logic [cnc_pkg::CfgW-1:0] map_bytes,
  input  logic                     step,
  output logic [AW-1:0]            idx,
  output logic                     last,
  output logic                     clr_busy,
  output logic [AW-1:0]            clr_addr
);

  localparam int LenW     = $clog2(MAP_ENTRIES + 1);
  localparam int CmpW     = (LenW > cnc_pkg::CfgW) ? LenW : cnc_pkg::CfgW;
  localparam int LenReset = (MAP_ENTRIES < cnc_pkg::MapBytesReset) ?
                            MAP_ENTRIES : cnc_pkg::MapBytesReset;

  logic [LenW-1:0] len;
  logic [LenW-1:0] len_next;
  logic [AW-1:0]   pos;
  logic [LenW-1:0] pos_inc;
  logic [CmpW-1:0] cfg_ext;

  // Clamp the written length to 1 .. MAP_ENTRIES
  always_comb begin
    cfg_ext = CmpW'(map_bytes);
    if (cfg_ext == '0) begin
      len_next = LenW'(1);
    end else if (cfg_ext > CmpW'(MAP_ENTRIES)) begin
      len_next = LenW'(MAP_ENTRIES);
    end else begin
      len_next = LenW'(cfg_ext);
    end
  end

  // Flag the last byte of an execution
  assign pos_inc = LenW'(pos) + LenW'(1);
  assign last    = (pos_inc >= len);
  assign idx     = pos;

  // Hold the length, advance the position
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LenW'(LenReset);
      pos <= '0;
    end else begin
      if (cfg_wr) begin
        len <= len_next;
      end
      if (step) begin
        pos <= last ? '0 : pos_inc[AW-1:0];
      end
    end
  end

  // Sweep every virgin word once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(MAP_ENTRIES - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  `CNC_ASSERT_NOW(a_no_step_while_clearing, clk, rst, clr_busy, !step)
  `CNC_ASSERT_NEXT(a_clear_runs_once, clk, rst, !clr_busy, !clr_busy)
  `CNC_ASSERT_NOW(a_len_in_range, clk, rst, 1'b1,
                  (len != '0) && (len <= LenW'(MAP_ENTRIES)))

endmodule
`default_nettype wire

@@ hw/rtl/cnc_update.sv @@
// Update stage: merge read data with forwarding, clear hit bits, track novelty.
`default_nettype none
`include "coverage_novelty_check_macros.svh"
module cnc_update #(
  parameter int AW = $clog2(cnc_pkg::MapEntriesDefault)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  input  cnc_pkg::s1_item_t         item,
  input  cnc_pkg::vword_t           rd_data,
  output logic                      s1_free,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output cnc_pkg::vword_t           wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cnc_pkg::ByteW-1:0] out_cls,
  output logic [1:0]                out_nov,
  output logic                      out_last
);

  logic                      s1_valid;
  cnc_pkg::s1_item_t         s1_item;
  logic [AW-1:0]             s1_addr;
  logic                      adv;
  logic                      fwd_valid;
  logic [AW-1:0]             fwd_addr;
  cnc_pkg::vword_t           fwd_data;
  cnc_pkg::vword_t           cur;
  logic [cnc_pkg::ByteW-1:0] v;
  logic                      hit;
  logic [1:0]                nov;
  logic [1:0]                nov_next;

  // Advance when the output register is free or being taken
  assign adv     = s1_valid && (!out_valid || out_ready);
  assign s1_free = !s1_valid || adv;

  // Take the word written on the same edge this item was read
  assign cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_data : rd_data;
  assign v   = cur[s1_item.lane];
  assign hit = |(s1_item.cls & v);

  // Clear the hit bits in the selected lane and raise novelty
  always_comb begin
    wr_data = cur;
    wr_data[s1_item.lane] = v & ~s1_item.cls;
    nov_next = nov;
    if (hit) begin
      if (v == 8'hFF) begin
        nov_next = cnc_pkg::NovTuples;
      end else if (nov != cnc_pkg::NovTuples) begin
        nov_next = cnc_pkg::NovCounts;
      end
    end
  end

  assign wr_en   = adv;
  assign wr_addr = s1_addr;

  // Hold the item beside its read word until it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_item <= item;
      s1_addr <= rd_addr;
    end
  end

  // Record the write that races the read on the same edge
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (rd_en) begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= wr_addr;
      fwd_data <= wr_data;
    end
  end

  // Running novelty, restarted after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      nov <= cnc_pkg::NovNone;
    end else if (adv) begin
      nov <= s1_item.last ? cnc_pkg::NovNone : nov_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cls  <= s1_item.cls;
      out_nov  <= nov_next;
      out_last <= s1_item.last;
    end
  end

  `CNC_ASSERT_NOW(a_no_read_while_stalled, clk, rst, s1_valid && !adv, !rd_en)
  `CNC_ASSERT_NEXT(a_nov_restarts, clk, rst, adv && s1_item.last,
                   nov == cnc_pkg::NovNone)
  `CNC_ASSERT_NEXT(a_tuples_stay, clk, rst,
                   adv && !s1_item.last && (nov == cnc_pkg::NovTuples),
                   nov == cnc_pkg::NovTuples)

endmodule
`default_nettype wire

@@ hw/rtl/coverage_novelty_check.sv @@
// Coverage novelty check top level: accept stage, virgin memory and update stage.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_ready     trace_byte, func
//   out       output     out_valid / out_ready   classified_byte, novelty, last_out
//   cfg       input      cfg_valid / cfg_ready   map_bytes
//
// One item per clock sustained while out_ready holds; an accepted item reads memory into
// the update stage, which writes the output register once that register is free or taken.
// Same-position reads right after a write take the written word by forwarding.
// After reset a clearing pass writes all MAP_ENTRIES virgin words, one per cycle;
// in_ready stays low throughout the pass while cfg writes are taken.
// A stalled output holds the update stage; with that stage full, in_ready drops
// until the output moves.
`default_nettype none
module coverage_novelty_check #(
  parameter int MAP_ENTRIES = cnc_pkg::MapEntriesDefault
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cnc_pkg::ByteW-1:0] trace_byte,
  input  logic [1:0]                func,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cnc_pkg::ByteW-1:0] classified_byte,
  output logic [1:0]                novelty,
  output logic                      last_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cnc_pkg::CfgW-1:0]  map_bytes
);

  localparam int AW = $clog2(MAP_ENTRIES);

  logic              accept;
  logic              s1_free;
  logic [AW-1:0]     idx;
  logic              last;
  logic              clr_busy;
  logic [AW-1:0]     clr_addr;
  cnc_pkg::s1_item_t item;
  cnc_pkg::vword_t   rd_data;
  logic              upd_wr_en;
  logic [AW-1:0]     upd_wr_addr;
  cnc_pkg::vword_t   upd_wr_data;
  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  cnc_pkg::vword_t   mem_wr_data;

  // Accept an item once the clearing pass is done and stage one can move
  assign cfg_ready = 1'b1;
  assign in_ready  = s1_free && !clr_busy;
  assign accept    = in_valid && in_ready;

  // Classify at accept time
  assign item.lane = cnc_pkg::lane_of(func);
  assign item.cls  = cnc_pkg::classify(trace_byte, func);
  assign item.last = last;

  // Clearing pass owns the write port until it ends
  assign mem_wr_en   = clr_busy || upd_wr_en;
  assign mem_wr_addr = clr_busy ? clr_addr : upd_wr_addr;
  assign mem_wr_data = clr_busy ? {3{8'hFF}} : upd_wr_data;

  cnc_seq #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .map_bytes (map_bytes),
    .step      (accept),
    .idx       (idx),
    .last      (last),
    .clr_busy  (clr_busy),
    .clr_addr  (clr_addr)
  );

  cnc_vmem #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .AW          (AW)
  ) u_vmem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (idx),
    .rd_data (rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  cnc_update #(
    .AW (AW)
  ) u_update (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (idx),
    .item      (item),
    .rd_data   (rd_data),
    .s1_free   (s1_free),
    .wr_en     (upd_wr_en),
    .wr_addr   (upd_wr_addr),
    .wr_data   (upd_wr_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_cls   (classified_byte),
    .out_nov   (novelty),
    .out_last  (last_out)
  );

endmodule
`default_nettype wire
